// ===== sv/ucd_pkg.sv =====
// ucd_pkg: shared types and constants of the UTF-8 code point decoder.
// Used by ucd_front, ucd_fifo, ucd_back and utf8_codepoint_decoder_top.
package ucd_pkg;

	localparam logic [20:0] REPL_CP  = 21'h00FFFD;
	localparam logic [20:0] MAX_CP   = 21'h10FFFF;
	localparam logic [20:0] MIN_CP2  = 21'h000080;
	localparam logic [20:0] MIN_CP3  = 21'h000800;
	localparam logic [20:0] MIN_CP4  = 21'h010000;

	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	// One input byte's worth of results: n results in total, all U+FFFD
	// except the one at mid_pos when mid_en is set.
	typedef struct packed {
		logic [2:0]  n;
		logic [1:0]  mid_pos;
		logic        mid_en;
		logic [20:0] mid_cp;
		logic        mid_repl;
	} job_t;

endpackage

// ===== sv/ucd_front.sv =====
// ucd_front: byte classification and pending-sequence state.
// Turns each accepted byte into one job_t descriptor. Depends on ucd_pkg.
module ucd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_byte,
	input  logic          end_of_text,
	input  logic          accept,
	output ucd_pkg::job_t job
);
	import ucd_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] lead_q;
	logic [5:0] pay_q [2];

	logic        cont;
	logic [2:0]  need;
	logic        complete;
	logic [20:0] v;
	logic [20:0] minv;
	logic [1:0]  pre;
	logic [1:0]  post;
	logic [1:0]  cnt_d;
	logic [1:0]  cnt_nx;
	logic [7:0]  lead_d;
	logic        pay_wr;
	logic        pay_idx;
	logic        mid_en;
	logic [20:0] mid_cp;
	logic        mid_repl;

	assign cont     = (in_byte[7:6] == 2'b10);
	assign complete = (({1'b0, cnt_q}) + 3'd1) >= need;
	assign pay_idx  = 1'(cnt_q - 2'd1);

	always_comb begin
		priority if (lead_q[7:5] == 3'b110) begin
			need = SEQ_LEN2;
			v    = {10'd0, lead_q[4:0], in_byte[5:0]};
			minv = MIN_CP2;
		end else if (lead_q[7:4] == 4'b1110) begin
			need = SEQ_LEN3;
			v    = {5'd0, lead_q[3:0], pay_q[0], in_byte[5:0]};
			minv = MIN_CP3;
		end else begin
			need = SEQ_LEN4;
			v    = {lead_q[2:0], pay_q[0], pay_q[1], in_byte[5:0]};
			minv = MIN_CP4;
		end
	end

	always_comb begin
		pre      = 2'd0;
		mid_en   = 1'b0;
		mid_cp   = {13'd0, in_byte};
		mid_repl = 1'b0;
		cnt_d    = cnt_q;
		lead_d   = lead_q;
		pay_wr   = 1'b0;
		if (cnt_q != 2'd0 && cont) begin
			if (complete) begin
				cnt_d  = 2'd0;
				mid_en = 1'b1;
				if (v < minv || v > MAX_CP) begin
					mid_cp   = REPL_CP;
					mid_repl = 1'b1;
				end else begin
					mid_cp = v;
				end
			end else begin
				pay_wr = 1'b1;
				cnt_d  = cnt_q + 2'd1;
			end
		end else begin
			pre   = cnt_q;
			cnt_d = 2'd0;
			priority if (!in_byte[7]) begin
				mid_en = 1'b1;
			end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110
					|| in_byte[7:3] == 5'b11110) begin
				lead_d = in_byte;
				cnt_d  = 2'd1;
			end else begin
				mid_en   = 1'b1;
				mid_cp   = REPL_CP;
				mid_repl = 1'b1;
			end
		end
		post   = end_of_text ? cnt_d : 2'd0;
		cnt_nx = end_of_text ? 2'd0 : cnt_d;
	end

	assign job.n        = {1'b0, pre} + {2'd0, mid_en} + {1'b0, post};
	assign job.mid_pos  = pre;
	assign job.mid_en   = mid_en;
	assign job.mid_cp   = mid_cp;
	assign job.mid_repl = mid_repl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lead_q <= lead_d;
			if (pay_wr) begin
				pay_q[pay_idx] <= in_byte[5:0];
			end
		end
	end

endmodule

// ===== sv/ucd_fifo.sv =====
// ucd_fifo: short show-ahead queue of job descriptors between front and back.
// Depends on ucd_pkg.
module ucd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ucd_pkg::job_t push_job,
	input  logic          pop,
	output ucd_pkg::job_t head,
	output logic          not_empty,
	output logic          full
);
	import ucd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == FULL_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== sv/ucd_back.sv =====
// ucd_back: expands job descriptors into code point transfers, one a cycle
// while out_ready allows, through an output register. Depends on ucd_pkg.
module ucd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ucd_pkg::job_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [20:0]   code_point,
	output logic          was_replaced,
	output logic          last_of_run
);
	import ucd_pkg::*;

	logic [1:0]  idx_q;
	logic        vld_q;
	logic [20:0] cp_q;
	logic        repl_q;
	logic        last_q;
	logic        advance;
	logic        is_last;
	logic        is_mid;

	assign advance = head_valid && (!vld_q || out_ready);
	assign is_last = (({1'b0, idx_q}) + 3'd1) == head.n;
	assign is_mid  = head.mid_en && (idx_q == head.mid_pos);
	assign pop     = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (advance) begin
				vld_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cp_q   <= is_mid ? head.mid_cp : REPL_CP;
			repl_q <= is_mid ? head.mid_repl : 1'b1;
			last_q <= is_last;
		end
	end

	assign out_valid    = vld_q;
	assign code_point   = cp_q;
	assign was_replaced = repl_q;
	assign last_of_run  = last_q;

endmodule

// ===== sv/utf8_codepoint_decoder_top.sv =====
// utf8_codepoint_decoder_top: streaming UTF-8 byte to code point decoder.
// Instantiates ucd_front, ucd_fifo and ucd_back; depends on ucd_pkg.
//
//   channel  | dir | tdata                   | tuser        | tlast
//   s_axis   | in  | [7:0] in_byte           | -            | end_of_text
//   m_axis   | out | [20:0] code_point, pad  | was_replaced | last_of_run
//
// One byte is taken per cycle while the job queue has room; each byte yields
// 0 to 4 code points, sent one per cycle from the output register while
// m_axis is ready. Sustained rate is one byte per cycle while bytes yield at
// most one result and m_axis is ready; bursts of replacements are absorbed by
// the QUEUE_DEPTH-entry job queue, which lies before the output register.
// Reset empties the pending sequence, the queue and the output register.
module utf8_codepoint_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
	output logic        m_axis_tuser,   // [0] was_replaced
	output logic        m_axis_tlast
);
	import ucd_pkg::*;

	job_t        job;
	job_t        head;
	logic        accept;
	logic        push;
	logic        pop;
	logic        not_empty;
	logic        full;
	logic [20:0] code_point;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && !full;
	assign push          = accept && (job.n != 3'd0);

	ucd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.accept      (accept),
		.job         (job)
	);

	ucd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (job),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	ucd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (not_empty),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.code_point   (code_point),
		.was_replaced (m_axis_tuser),
		.last_of_run  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, code_point};

	a_repl_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> code_point == REPL_CP)
		else $error("replacement transfer without U+FFFD");

	a_scalar_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> code_point <= MAX_CP)
		else $error("code point above U+10FFFF");

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> job.n <= 3'd4 && (!job.mid_en || job.mid_pos < job.n[1:0]
			|| job.n == 3'd4))
		else $error("malformed job descriptor");

endmodule
